// ===== design/adpr_pkg.sv =====
// Shared types, constants and helpers of the adaptive DPCM pixel reconstructor.
package adpr_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int RESIDUAL_W   = 17;
	localparam int PIXEL_W      = 16;
	localparam int STORE_W      = 32;
	localparam int LINE_WIDTH_W = 11;
	localparam int LINE_TOTAL_W = 16;
	localparam int APB_ADDR_W   = 4;
	localparam int APB_DATA_W   = 32;

	localparam logic [STORE_W-1:0] GRAD_LIMIT = 32'd1000;

	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd256;
	localparam logic [LINE_TOTAL_W-1:0] LINE_TOTAL_RESET = 16'd256;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_LINE_WIDTH      = 2'd0;
	localparam logic [1:0] REG_LINE_TOTAL      = 2'd1;
	localparam logic [1:0] REG_SKIP_PREDICTION = 2'd2;

	typedef logic [1:0]         buf_t;
	typedef logic [STORE_W-1:0] word_t;

	// Neighbors of the pixel being decoded: U is the line above, D the line above that.
	typedef struct packed {
		word_t u_m1;
		word_t u_0;
		word_t u_p1;
		word_t d_m2;
		word_t d_0;
		word_t d_p2;
	} nbr_t;

	// Which gradients may be used and how the pixel is stored.
	typedef struct packed {
		logic col_gt0;
		logic col_gt1;
		logic row_gt1;
		logic anti_ok;
		logic skip;
	} cond_t;

	// Line buffer roles now and after the current item.
	typedef struct packed {
		logic fire;
		logic new_line;
		buf_t cur;
		buf_t up;
		buf_t up2;
		buf_t nxt_up;
		buf_t nxt_up2;
	} step_t;

	function automatic buf_t buf_next(input buf_t b);
		buf_next = (b == 2'd2) ? 2'd0 : buf_t'(b + 2'd1);
	endfunction

endpackage

// ===== design/adpr_res_if.sv =====
// Residual input channel with valid/ready handshake.
interface adpr_res_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [adpr_pkg::RESIDUAL_W-1:0]   residual;

	modport source (output valid, output residual, input ready);
	modport sink (input valid, input residual, output ready);
endinterface

// ===== design/adpr_pix_if.sv =====
// Reconstructed pixel output channel with valid/ready handshake.
interface adpr_pix_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [adpr_pkg::PIXEL_W-1:0]   pixel;
	logic                                  frame_last;

	modport source (output valid, output pixel, output frame_last, input ready);
	modport sink (input valid, input pixel, input frame_last, output ready);
endinterface

// ===== design/adpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module adpr_ram #(
	parameter int WIDTH = adpr_pkg::STORE_W,
	parameter int DEPTH = adpr_pkg::MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/adpr_window.sv =====
// Line buffers and the sliding neighbor window over the two previous lines.
module adpr_window #(
	parameter int MAX_WIDTH = adpr_pkg::MAX_WIDTH
) (
	input  logic                         clk,
	input  adpr_pkg::step_t              step,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  logic [$clog2(MAX_WIDTH)-1:0] nxt_col,
	input  adpr_pkg::word_t              val,
	output adpr_pkg::nbr_t               nbr
);

	localparam int CW = $clog2(MAX_WIDTH);

	adpr_pkg::word_t ram_q [3];
	// Copies of columns 0..2 of each buffer, so a new line starts without any RAM read.
	adpr_pkg::word_t head_q [3][3];

	adpr_pkg::word_t u_m1_q, u_0_q;
	adpr_pkg::word_t d_m2_q, d_m1_q, d_0_q, d_p1_q;
	adpr_pkg::word_t u_p1, d_p2;
	adpr_pkg::word_t new_u0, new_d0, new_d1;

	for (genvar b = 0; b < 3; b++) begin : g_buf
		logic          we_b;
		logic [CW-1:0] raddr_b;

		assign we_b    = step.fire && (step.cur == adpr_pkg::buf_t'(b));
		assign raddr_b = (step.nxt_up == adpr_pkg::buf_t'(b)) ? CW'(nxt_col + CW'(1))
		                                                        : CW'(nxt_col + CW'(2));

		adpr_ram #(
			.WIDTH (adpr_pkg::STORE_W),
			.DEPTH (MAX_WIDTH)
		) u_ram (
			.clk   (clk),
			.we    (we_b),
			.waddr (col),
			.wdata (val),
			.re    (step.fire),
			.raddr (raddr_b),
			.rdata (ram_q[b])
		);
	end

	// Values ahead of the window come from the head copies near the line start.
	always_comb begin
		if (col == CW'(0)) begin
			u_p1 = head_q[step.up][1];
			d_p2 = head_q[step.up2][2];
		end else if (col == CW'(1)) begin
			u_p1 = head_q[step.up][2];
			d_p2 = ram_q[step.up2];
		end else begin
			u_p1 = ram_q[step.up];
			d_p2 = ram_q[step.up2];
		end
	end

	// Start-of-line values, with the pixel written in this cycle forwarded.
	always_comb begin
		new_u0 = head_q[step.nxt_up][0];
		new_d0 = head_q[step.nxt_up2][0];
		new_d1 = head_q[step.nxt_up2][1];
		if (step.nxt_up == step.cur && col == CW'(0)) begin
			new_u0 = val;
		end
		if (step.nxt_up2 == step.cur && col == CW'(0)) begin
			new_d0 = val;
		end
		if (step.nxt_up2 == step.cur && col == CW'(1)) begin
			new_d1 = val;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire) begin
			if (col < CW'(3)) begin
				head_q[step.cur][col[1:0]] <= val;
			end
			u_m1_q <= u_0_q;
			d_m2_q <= d_m1_q;
			d_m1_q <= d_0_q;
			if (step.new_line) begin
				u_0_q  <= new_u0;
				d_0_q  <= new_d0;
				d_p1_q <= new_d1;
			end else begin
				u_0_q  <= u_p1;
				d_0_q  <= d_p1_q;
				d_p1_q <= d_p2;
			end
		end
	end

	assign nbr.u_m1 = u_m1_q;
	assign nbr.u_0  = u_0_q;
	assign nbr.u_p1 = u_p1;
	assign nbr.d_m2 = d_m2_q;
	assign nbr.d_0  = d_0_q;
	assign nbr.d_p2 = d_p2;

endmodule

// ===== design/adpr_predict.sv =====
// Gradient measurement, predictor choice and pixel reconstruction.
module adpr_predict (
	input  logic signed [adpr_pkg::RESIDUAL_W-1:0] residual,
	input  adpr_pkg::nbr_t                         nbr,
	input  adpr_pkg::word_t                        left0,
	input  adpr_pkg::word_t                        left1,
	input  adpr_pkg::cond_t                        cond,
	output adpr_pkg::word_t                        val
);

	localparam logic [2:0] PRED_NONE    = 3'd0;
	localparam logic [2:0] PRED_LEFT    = 3'd1;
	localparam logic [2:0] PRED_UP      = 3'd2;
	localparam logic [2:0] PRED_UPLEFT  = 3'd3;
	localparam logic [2:0] PRED_UPRIGHT = 3'd4;

	function automatic adpr_pkg::word_t magnitude(input adpr_pkg::word_t a,
	                                              input adpr_pkg::word_t b);
		adpr_pkg::word_t d;
		d = a - b;
		magnitude = d[adpr_pkg::STORE_W-1] ? adpr_pkg::word_t'(-d) : d;
	endfunction

	adpr_pkg::word_t res, g_h, g_v, g_d, g_a, best, pv;
	logic [2:0]      pred;

	assign res = adpr_pkg::word_t'(residual);
	assign g_h = magnitude(left0, left1);
	assign g_v = magnitude(nbr.u_0, nbr.d_0);
	assign g_d = magnitude(nbr.u_m1, nbr.d_m2);
	assign g_a = magnitude(nbr.u_p1, nbr.d_p2);

	// Strict compares keep ties with the earlier gradient.
	always_comb begin
		best = adpr_pkg::GRAD_LIMIT;
		pred = PRED_NONE;
		if (cond.col_gt1 && g_h < best) begin
			best = g_h;
			pred = PRED_LEFT;
		end
		if (cond.row_gt1 && g_v < best) begin
			best = g_v;
			pred = PRED_UP;
		end
		if (cond.row_gt1 && cond.col_gt1 && g_d < best) begin
			best = g_d;
			pred = PRED_UPLEFT;
		end
		if (cond.anti_ok && g_a < best) begin
			pred = PRED_UPRIGHT;
		end
	end

	always_comb begin
		case (pred)
			PRED_UP:      pv = nbr.u_0;
			PRED_UPLEFT:  pv = nbr.u_m1;
			PRED_UPRIGHT: pv = nbr.u_p1;
			default:      pv = cond.col_gt0 ? left0 : '0;
		endcase
		val = cond.skip ? res : res + pv;
	end

endmodule

// ===== design/adaptive_dpcm_pixel_reconstructor_core.sv =====
// Top level of the adaptive DPCM pixel reconstructor: position tracking, registers, output stage.
// Each result is registered in the output register, or in the skid register while it is stalled.
// Throughput: one item per cycle while the skid register is free; the gradient choice and the
// add sit between the position and window registers and the output register, and the line RAMs
// are read one column ahead. On an output stall, ready stays high until the skid register fills.
// Reset (arst_n low) clears positions, rotation, left pixels and the output stage and sets the
// registers to their defaults; the line RAMs are not cleared and need no clearing pass.
module adaptive_dpcm_pixel_reconstructor_core #(
	parameter int MAX_WIDTH = adpr_pkg::MAX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	adpr_res_if.sink                            residuals,
	adpr_pix_if.source                          pixels,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adpr_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [adpr_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [adpr_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int LW   = adpr_pkg::LINE_WIDTH_W;
	localparam int CMPW = (LW > CW + 1) ? LW : CW + 1;
	localparam int TW   = adpr_pkg::LINE_TOTAL_W;

	// Configuration registers.
	logic [LW-1:0] line_width_q;
	logic [TW-1:0] line_total_q;
	logic          skip_q;

	// Position in the frame and the buffer that holds the current line.
	logic [CW-1:0]   col_q;
	logic [TW-1:0]   row_q;
	adpr_pkg::buf_t  rot_q;
	adpr_pkg::word_t left0_q, left1_q;

	// Output register and the skid register behind it.
	logic                                  o_valid_q, sk_valid_q;
	logic signed [adpr_pkg::PIXEL_W-1:0]   o_pixel_q, sk_pixel_q;
	logic                                  o_last_q, sk_last_q;

	logic            cfg_wr, fire, out_take;
	logic [CMPW-1:0] w_ext, w_eff, col_ext;
	logic [TW-1:0]   h_eff;
	logic            line_end, frame_end;
	logic [CW-1:0]   nxt_col;
	adpr_pkg::buf_t  nrot;
	adpr_pkg::step_t step;
	adpr_pkg::cond_t cond;
	adpr_pkg::nbr_t  nbr;
	adpr_pkg::word_t val;

	// Register port: writes complete in the access phase, pready is tied high.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= adpr_pkg::LINE_WIDTH_RESET;
			line_total_q <= adpr_pkg::LINE_TOTAL_RESET;
			skip_q       <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				adpr_pkg::REG_LINE_WIDTH:      line_width_q <= pwdata[LW-1:0];
				adpr_pkg::REG_LINE_TOTAL:      line_total_q <= pwdata[TW-1:0];
				adpr_pkg::REG_SKIP_PREDICTION: skip_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			adpr_pkg::REG_LINE_WIDTH:      prdata = adpr_pkg::APB_DATA_W'(line_width_q);
			adpr_pkg::REG_LINE_TOTAL:      prdata = adpr_pkg::APB_DATA_W'(line_total_q);
			adpr_pkg::REG_SKIP_PREDICTION: prdata = adpr_pkg::APB_DATA_W'(skip_q);
			default:                       prdata = '0;
		endcase
	end

	// The input is ready whenever the skid register is free.
	assign residuals.ready = !sk_valid_q;
	assign fire            = residuals.valid && !sk_valid_q;
	assign out_take        = o_valid_q && pixels.ready;

	// A width of zero counts as one and a width above the line buffers is clamped to them;
	// a line total of zero counts as one.
	always_comb begin
		w_ext = CMPW'(line_width_q);
		if (w_ext == CMPW'(0)) begin
			w_eff = CMPW'(1);
		end else if (w_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff = (line_total_q == '0) ? TW'(1) : line_total_q;
	end

	assign col_ext   = CMPW'(col_q);
	assign line_end  = (col_ext + CMPW'(1)) >= w_eff;
	assign frame_end = line_end && (({1'b0, row_q} + (TW+1)'(1)) >= {1'b0, h_eff});
	assign nxt_col   = line_end ? '0 : CW'(col_q + CW'(1));

	// The line just finished becomes the line above; a new frame restarts the rotation.
	assign nrot = frame_end ? '0 : (line_end ? adpr_pkg::buf_next(rot_q) : rot_q);

	always_comb begin
		step.fire     = fire;
		step.new_line = line_end;
		step.cur      = rot_q;
		step.up2      = adpr_pkg::buf_next(rot_q);
		step.up       = adpr_pkg::buf_next(adpr_pkg::buf_next(rot_q));
		step.nxt_up2  = adpr_pkg::buf_next(nrot);
		step.nxt_up   = adpr_pkg::buf_next(adpr_pkg::buf_next(nrot));
	end

	// Each gradient needs both of its neighbors to lie inside the image.
	always_comb begin
		cond.col_gt0 = col_q != '0;
		cond.col_gt1 = col_q > CW'(1);
		cond.row_gt1 = row_q > TW'(1);
		cond.anti_ok = (row_q > TW'(1)) && ((col_ext + CMPW'(2)) < w_eff);
		cond.skip    = skip_q;
	end

	adpr_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk     (clk),
		.step    (step),
		.col     (col_q),
		.nxt_col (nxt_col),
		.val     (val),
		.nbr     (nbr)
	);

	adpr_predict u_predict (
		.residual (residuals.residual),
		.nbr      (nbr),
		.left0    (left0_q),
		.left1    (left1_q),
		.cond     (cond),
		.val      (val)
	);

	// Position counters and the two left pixels of the current line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			rot_q   <= '0;
			left0_q <= '0;
			left1_q <= '0;
		end else if (fire) begin
			col_q <= nxt_col;
			rot_q <= nrot;
			if (frame_end) begin
				row_q <= '0;
			end else if (line_end) begin
				row_q <= TW'(row_q + TW'(1));
			end
			if (line_end) begin
				left0_q <= '0;
				left1_q <= '0;
			end else begin
				left0_q <= val;
				left1_q <= left0_q;
			end
		end
	end

	// Output stage: the skid register catches one item while the output register is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (!o_valid_q || out_take) begin
			o_valid_q  <= sk_valid_q || fire;
			sk_valid_q <= 1'b0;
		end else if (fire) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_valid_q || out_take) begin
			if (sk_valid_q) begin
				o_pixel_q <= sk_pixel_q;
				o_last_q  <= sk_last_q;
			end else begin
				o_pixel_q <= $signed(val[adpr_pkg::PIXEL_W-1:0]);
				o_last_q  <= frame_end;
			end
		end else if (fire) begin
			sk_pixel_q <= $signed(val[adpr_pkg::PIXEL_W-1:0]);
			sk_last_q  <= frame_end;
		end
	end

	assign pixels.valid      = o_valid_q;
	assign pixels.pixel      = o_pixel_q;
	assign pixels.frame_last = o_last_q;

	// The skid register only ever holds an item behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> o_valid_q)
		else $error("skid register holds an item while the output register is empty");

	// The end of a frame returns every position counter and the rotation to zero.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && frame_end) |=> (col_q == '0 && row_q == '0 && rot_q == '0))
		else $error("positions not cleared after the last item of a frame");

	// Inside a line the column advances by exactly one per item.
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !line_end) |=> (col_q == CW'($past(col_q) + CW'(1))))
		else $error("column did not advance by one within a line");

	// The rotation only takes the three buffer numbers and the column stays inside a buffer.
	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_q != 2'd3) && (CMPW'(col_q) < CMPW'(MAX_WIDTH)))
		else $error("line buffer position out of range");

endmodule
